// File: design/assert_macros.svh
// assertion macros for the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/cspt_pkg.sv
// types, constants and register codes for the cyclic signal pause timer
// no dependencies
package cspt_pkg;

  localparam int SIGNAL_W = 17;
  localparam int DELAY_W  = 16;
  localparam int COUNT_W  = 18;
  localparam int TOTAL_W  = 32;
  localparam int CFG_W    = 17;

  localparam logic [SIGNAL_W-1:0] SIGNAL_TIME_RESET    = 17'd45000;
  localparam logic [SIGNAL_W-1:0] PAUSE_TIME_RESET     = 17'd150;
  localparam logic [DELAY_W-1:0]  RUN_DELAY_RESET      = 16'd1000;
  localparam logic [DELAY_W-1:0]  TRIGGER_FILTER_RESET = 16'd1000;

  // run tick count at which single-pulse mode is armed without a pulse
  localparam logic [DELAY_W-1:0] RUN_ARM_TICKS = 16'd10;

  typedef enum logic [1:0] {
    CFG_SIGNAL_TIME    = 2'd0,
    CFG_PAUSE_TIME     = 2'd1,
    CFG_RUN_DELAY      = 2'd2,
    CFG_TRIGGER_FILTER = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [SIGNAL_W-1:0] signal_time;
    logic [SIGNAL_W-1:0] pause_time;
    logic [DELAY_W-1:0]  run_delay;
    logic [DELAY_W-1:0]  trigger_filter;
  } regs_t;

  typedef struct packed {
    logic [DELAY_W-1:0] run_ticks;
    logic [COUNT_W-1:0] signal_count;
    logic [COUNT_W-1:0] period_count;
    logic [TOTAL_W-1:0] cycle_total;
    logic [DELAY_W-1:0] trigger_ticks;
    logic               trigger_latched;
    logic               drive_level;
  } state_t;

endpackage

// File: design/cspt_in_if.sv
// tick input channel: valid/ready handshake with run, trigger and clear levels
// depends on nothing
interface cspt_in_if;
  logic valid;
  logic ready;
  logic run_level;
  logic trigger_level;
  logic clear_count;

  modport source (output valid, run_level, trigger_level, clear_count, input ready);
  modport sink   (input valid, run_level, trigger_level, clear_count, output ready);
endinterface

// File: design/cspt_out_if.sv
// result channel: valid/ready handshake with output level and cycle counter
// depends on nothing
interface cspt_out_if;
  logic        valid;
  logic        ready;
  logic        out_level;
  logic [31:0] cycles_done;
  logic        cycle_end;

  modport source (output valid, out_level, cycles_done, cycle_end, input ready);
  modport sink   (input valid, out_level, cycles_done, cycle_end, output ready);
endinterface

// File: design/cspt_cfg_if.sv
// configuration write channel: valid/ready handshake with index and data
// depends on cspt_pkg
interface cspt_cfg_if;
  logic                          valid;
  logic                          ready;
  cspt_pkg::cfg_index_t          index;
  logic [cspt_pkg::CFG_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: design/cspt_step.sv
// next-state logic for one 1 ms tick of the timer
// depends on cspt_pkg
module cspt_step (
  input  cspt_pkg::regs_t  regs,
  input  cspt_pkg::state_t state,
  input  logic             run_level,
  input  logic             trigger_level,
  input  logic             clear_count,
  output cspt_pkg::state_t state_next,
  output logic             ended
);

  logic [cspt_pkg::DELAY_W-1:0] run_ticks_next;
  logic [cspt_pkg::DELAY_W-1:0] trigger_ticks_next;
  logic [cspt_pkg::COUNT_W-1:0] signal_inc;
  logic [cspt_pkg::COUNT_W-1:0] period_inc;
  logic [cspt_pkg::COUNT_W-1:0] elapsed;
  logic [cspt_pkg::COUNT_W-1:0] total;
  logic [cspt_pkg::COUNT_W-1:0] signal_ext;
  logic                         pulse_mode;

  // saturating counters and shared comparison operands
  assign run_ticks_next = !run_level ? '0 :
                          (&state.run_ticks) ? state.run_ticks : state.run_ticks + 1'b1;
  assign trigger_ticks_next = !trigger_level ? '0 :
                              (&state.trigger_ticks) ? state.trigger_ticks
                                                     : state.trigger_ticks + 1'b1;
  assign signal_inc = (&state.signal_count) ? state.signal_count
                                            : state.signal_count + 1'b1;
  assign period_inc = (&state.period_count) ? state.period_count
                                            : state.period_count + 1'b1;
  assign elapsed    = signal_inc - 1'b1;
  assign signal_ext = {1'b0, regs.signal_time};
  assign total      = {1'b0, regs.signal_time} + {1'b0, regs.pause_time};
  assign pulse_mode = (regs.pause_time == '0);

  // tick sequence: phase step, run stop, arm, clear, trigger
  always_comb begin
    state_next = state;
    ended      = 1'b0;
    state_next.run_ticks     = run_ticks_next;
    state_next.trigger_ticks = trigger_ticks_next;

    // phase step once the run delay has passed
    if (run_ticks_next > regs.run_delay) begin
      state_next.signal_count = signal_inc;
      state_next.period_count = period_inc;
      if (!pulse_mode) begin
        if (signal_inc < signal_ext) begin
          state_next.drive_level = 1'b1;
        end
        if (signal_inc > signal_ext && period_inc <= total) begin
          state_next.drive_level = 1'b0;
        end
        if (period_inc >= total) begin
          state_next.signal_count = '0;
          state_next.period_count = '0;
          state_next.cycle_total  = state.cycle_total + 1'b1;
          ended = 1'b1;
        end
      end else begin
        if (elapsed < signal_ext) begin
          state_next.drive_level = 1'b1;
        end
        if (elapsed == signal_ext) begin
          state_next.drive_level = 1'b0;
        end
      end
    end

    // run switch low: output off, phase counters cleared
    if (run_ticks_next == '0) begin
      state_next.drive_level  = 1'b0;
      state_next.signal_count = '0;
      state_next.period_count = '0;
    end

    // single-pulse mode waits for a trigger after arming
    if (run_ticks_next == cspt_pkg::RUN_ARM_TICKS && pulse_mode) begin
      state_next.signal_count = signal_ext + 1'b1;
    end

    if (clear_count) begin
      state_next.cycle_total = '0;
    end

    // debounced trigger edge
    if (!trigger_level) begin
      state_next.trigger_latched = 1'b0;
    end
    if (trigger_ticks_next > regs.trigger_filter && !state_next.trigger_latched) begin
      state_next.trigger_latched = 1'b1;
      if (state_next.signal_count > signal_ext) begin
        state_next.signal_count = '0;
        state_next.period_count = '0;
        state_next.cycle_total  = state_next.cycle_total + 1'b1;
        ended = 1'b1;
      end
    end
  end

endmodule

// File: design/cyclic_signal_pause_timer.sv
// top level of the cyclic signal pause timer
// depends on cspt_pkg, cspt_in_if, cspt_out_if, cspt_cfg_if and cspt_step
//
// Each accepted tick transaction is one 1 ms time step. The result for a tick
// appears in the cycle after it is accepted and stays in the output register
// until taken; a new tick is accepted in the same cycle the previous result
// is taken, so the block sustains one tick per clock while each result is
// taken as soon as it is offered. The result is held in the state register
// that the tick logic updates. The configuration port is always ready and
// should only be written while no result is pending.
module cyclic_signal_pause_timer (
  input logic        clk,
  input logic        rst,
  cspt_in_if.sink    tick_in,
  cspt_out_if.source result_out,
  cspt_cfg_if.sink   cfg
);

  cspt_pkg::regs_t  regs;
  cspt_pkg::state_t state;
  cspt_pkg::state_t state_next;
  logic             ended;
  logic             cycle_end;
  logic             out_valid;
  logic             tick_accept;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.signal_time    <= cspt_pkg::SIGNAL_TIME_RESET;
      regs.pause_time     <= cspt_pkg::PAUSE_TIME_RESET;
      regs.run_delay      <= cspt_pkg::RUN_DELAY_RESET;
      regs.trigger_filter <= cspt_pkg::TRIGGER_FILTER_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        cspt_pkg::CFG_SIGNAL_TIME:    regs.signal_time    <= cfg.data;
        cspt_pkg::CFG_PAUSE_TIME:     regs.pause_time     <= cfg.data;
        cspt_pkg::CFG_RUN_DELAY:      regs.run_delay      <= cfg.data[cspt_pkg::DELAY_W-1:0];
        cspt_pkg::CFG_TRIGGER_FILTER: regs.trigger_filter <= cfg.data[cspt_pkg::DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // tick handshake: take a tick whenever the result slot is free or draining
  assign tick_in.ready = !out_valid || result_out.ready;
  assign tick_accept   = tick_in.valid && tick_in.ready;

  cspt_step u_step (
    .regs          (regs),
    .state         (state),
    .run_level     (tick_in.run_level),
    .trigger_level (tick_in.trigger_level),
    .clear_count   (tick_in.clear_count),
    .state_next    (state_next),
    .ended         (ended)
  );

  // timer state, which also holds the result payload
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      cycle_end <= 1'b0;
    end else if (tick_accept) begin
      state     <= state_next;
      cycle_end <= ended;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tick_accept) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign result_out.valid       = out_valid;
  assign result_out.out_level   = state.drive_level;
  assign result_out.cycles_done = state.cycle_total;
  assign result_out.cycle_end   = cycle_end;

endmodule

// File: design/cspt_checker.sv
// port-level checks for the cyclic signal pause timer, bound to the top level
// depends on assert_macros.svh and cyclic_signal_pause_timer
`include "assert_macros.svh"

module cspt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_run_level,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_level,
  input logic [31:0] out_cycles_done,
  input logic        out_cycle_end
);

  logic in_fire;
  logic out_stall;

  assign in_fire   = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;

  // a stalled result stays offered
  `ASSERT_NEXT(a_out_hold, clk, rst, out_stall, out_valid)

  // a stalled result keeps its payload
  `ASSERT_NEXT(a_out_stable, clk, rst, out_stall,
    $stable(out_level) && $stable(out_cycles_done) && $stable(out_cycle_end))

  // every accepted tick has its result in the next cycle
  `ASSERT_NEXT(a_tick_result, clk, rst, in_fire, out_valid)

  // run switch low forces the output off and ends no cycle
  `ASSERT_NEXT(a_run_off, clk, rst, in_fire && !in_run_level,
    !out_level && !out_cycle_end)

endmodule

bind cyclic_signal_pause_timer cspt_checker u_cspt_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (tick_in.valid),
  .in_ready        (tick_in.ready),
  .in_run_level    (tick_in.run_level),
  .out_valid       (result_out.valid),
  .out_ready       (result_out.ready),
  .out_level       (result_out.out_level),
  .out_cycles_done (result_out.cycles_done),
  .out_cycle_end   (result_out.cycle_end)
);
